// ----- sv/lts_pkg.sv -----
package lts_pkg;

    // Table geometry.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Payload widths.
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming transaction
        logic step;        // examine the current entry and advance
        logic mark;        // first match of a delete found
        logic shift;       // move one entry down
        logic shrink;      // drop the last entry after a delete
        logic emit_final;  // write the closing result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_walk;
        logic is_search;
        logic is_delete;
        logic at_end;
        logic match;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/lts_ctrl.sv -----
module lts_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  lts_pkg::stat_t stat,
    output lts_pkg::cmd_t  cmd
);

    lts_pkg::state_t state_reg;
    lts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            lts_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lts_pkg::S_WALK;
                end
            end
            lts_pkg::S_WALK:
            begin
                if (!stat.is_walk || stat.at_end)
                begin
                    state_next = lts_pkg::S_DONE;
                end
                else if (stat.is_delete && stat.match)
                begin
                    cmd.mark   = 1'b1;
                    state_next = lts_pkg::S_SHIFT;
                end
                else if (!(stat.is_search && stat.match) || stat.out_free)
                begin
                    // A search hit waits here until the output register can take it.
                    cmd.step = 1'b1;
                end
            end
            lts_pkg::S_SHIFT:
            begin
                if (stat.at_end)
                begin
                    cmd.shrink = 1'b1;
                    state_next = lts_pkg::S_DONE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            lts_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = lts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/lts_dp.sv -----
module lts_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lts_pkg::cmd_t                     cmd,
    output lts_pkg::stat_t                    stat,
    input  logic [lts_pkg::OP_W-1:0]          op,
    input  logic signed [lts_pkg::DATA_W-1:0] key,
    input  logic signed [lts_pkg::DATA_W-1:0] new_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lts_pkg::IDX_W-1:0]         index,
    output logic                              hit,
    output logic [lts_pkg::CNT_W-1:0]         tally,
    output logic [lts_pkg::STAT_W-1:0]        status,
    output logic                              last
);

    localparam logic [lts_pkg::CNT_W-1:0] DEPTH_C = lts_pkg::CNT_W'(lts_pkg::DEPTH);

    logic [lts_pkg::DATA_W-1:0] entries [lts_pkg::DEPTH];

    logic [lts_pkg::OP_W-1:0]   op_reg;
    logic [lts_pkg::DATA_W-1:0] key_reg;
    logic [lts_pkg::DATA_W-1:0] nv_reg;
    logic [lts_pkg::CNT_W-1:0]  ptr_reg;
    logic [lts_pkg::CNT_W-1:0]  ptr_next;
    logic [lts_pkg::CNT_W-1:0]  cnt_reg;
    logic [lts_pkg::CNT_W-1:0]  cnt_next;
    logic [lts_pkg::IDX_W-1:0]  del_idx_reg;
    logic                       found_reg;
    logic [lts_pkg::CNT_W-1:0]  fill_reg;
    logic [lts_pkg::CNT_W-1:0]  fill_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lts_pkg::IDX_W-1:0]   index_reg;
    logic                        hit_reg;
    logic [lts_pkg::CNT_W-1:0]   tally_reg;
    logic [lts_pkg::STAT_W-1:0]  status_reg;
    logic                        last_reg;

    logic [lts_pkg::DATA_W-1:0] rd_data;
    logic                       match;
    logic                       has_room;
    logic                       is_search;
    logic                       is_replace;
    logic                       is_delete;

    logic                        emit;
    logic [lts_pkg::IDX_W-1:0]   e_index;
    logic                        e_hit;
    logic [lts_pkg::CNT_W-1:0]   e_tally;
    logic [lts_pkg::STAT_W-1:0]  e_status;
    logic                        e_last;

    logic                        wr_en;
    logic [lts_pkg::IDX_W-1:0]   wr_addr;
    logic [lts_pkg::DATA_W-1:0]  wr_data;

    // The walk pointer is the only read address into the table.
    assign rd_data    = entries[ptr_reg[lts_pkg::IDX_W-1:0]];
    assign match      = (rd_data == key_reg);
    assign has_room   = (fill_reg < DEPTH_C);
    assign is_search  = (op_reg == lts_pkg::OP_SEARCH);
    assign is_replace = (op_reg == lts_pkg::OP_REPLACE);
    assign is_delete  = (op_reg == lts_pkg::OP_DELETE);

    always_comb
    begin
        stat.is_walk   = op_reg inside {lts_pkg::OP_SEARCH, lts_pkg::OP_REPLACE,
                                        lts_pkg::OP_DELETE};
        stat.is_search = is_search;
        stat.is_delete = is_delete;
        stat.at_end    = (ptr_reg == fill_reg);
        stat.match     = match;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // Result selection.
    always_comb
    begin
        emit     = 1'b0;
        e_index  = '0;
        e_hit    = 1'b0;
        e_tally  = fill_reg;
        e_status = lts_pkg::ST_OK;
        e_last   = 1'b1;
        if (cmd.step && is_search && match)
        begin
            emit    = 1'b1;
            e_index = ptr_reg[lts_pkg::IDX_W-1:0];
            e_hit   = 1'b1;
            e_tally = cnt_reg + 1'b1;
            e_last  = 1'b0;
        end
        else if (cmd.emit_final)
        begin
            emit = 1'b1;
            case (op_reg)
                lts_pkg::OP_CLEAR:
                begin
                    e_hit   = 1'b1;
                    e_tally = '0;
                end
                lts_pkg::OP_APPEND:
                begin
                    if (has_room)
                    begin
                        e_index = fill_reg[lts_pkg::IDX_W-1:0];
                        e_hit   = 1'b1;
                        e_tally = fill_reg + 1'b1;
                    end
                    else
                    begin
                        e_status = lts_pkg::ST_FULL;
                    end
                end
                lts_pkg::OP_SEARCH, lts_pkg::OP_REPLACE:
                begin
                    e_hit    = (cnt_reg != '0);
                    e_tally  = cnt_reg;
                    e_status = (cnt_reg != '0) ? lts_pkg::ST_OK : lts_pkg::ST_NOT_FOUND;
                end
                lts_pkg::OP_DELETE:
                begin
                    if (found_reg)
                    begin
                        e_index = del_idx_reg;
                        e_hit   = 1'b1;
                    end
                    else
                    begin
                        e_status = lts_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    e_status = lts_pkg::ST_OK;
                end
            endcase
        end
    end

    // Table write port: replace hit, delete shift, or append.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[lts_pkg::IDX_W-1:0];
        wr_data = nv_reg;
        if (cmd.step && is_replace && match)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg[lts_pkg::IDX_W-1:0] - 1'b1;
            wr_data = rd_data;
        end
        else if (cmd.emit_final && (op_reg == lts_pkg::OP_APPEND) && has_room)
        begin
            wr_en   = 1'b1;
            wr_addr = fill_reg[lts_pkg::IDX_W-1:0];
            wr_data = key_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = '0;
        end
        else if (cmd.step || cmd.mark || cmd.shift)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.step && match && (is_search || is_replace))
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        fill_next = fill_reg;
        if (cmd.shrink)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (cmd.emit_final && (op_reg == lts_pkg::OP_CLEAR))
        begin
            fill_next = '0;
        end
        else if (cmd.emit_final && (op_reg == lts_pkg::OP_APPEND) && has_room)
        begin
            fill_next = fill_reg + 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.mark)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key;
            nv_reg  <= new_value;
        end
        if (cmd.mark)
        begin
            del_idx_reg <= ptr_reg[lts_pkg::IDX_W-1:0];
        end
        if (emit)
        begin
            index_reg  <= e_index;
            hit_reg    <= e_hit;
            tally_reg  <= e_tally;
            status_reg <= e_status;
            last_reg   <= e_last;
        end
        if (wr_en)
        begin
            entries[wr_addr] <= wr_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign index     = index_reg;
    assign hit       = hit_reg;
    assign tally     = tally_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ----- sv/linear_table_search_edit_unit.sv -----
// Linear table search and edit unit.
//
// The block keeps an unsorted table of up to sixteen signed 32-bit values
// and a fill count. Each input transaction (in_valid, in_stall) carries an
// op code with a key and a replacement value: clear, append, search, replace
// or delete. Results leave on the output channel (out_valid, out_stall), one
// transaction per result; the final result of an operation has last set.
// Search gives one result per matching entry and then a closing result.
//
// One operation is in flight at a time. The input is taken only while the
// controller is idle. Clear, append and unknown codes do not walk the table.
// Search and replace walk the filled part of the table one entry per cycle,
// except that a search hit pauses the walk while the output register is
// occupied. Delete walks to the first match and then moves each later
// entry down one place per cycle. The single table read port is addressed
// by the walk pointer.
//
// Reset empties the table and drops any pending result. While the receiver
// stalls, a finished result is held in the output register; a search hit or
// closing result that finds the register occupied waits, pausing the walk.
module linear_table_search_edit_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lts_pkg::OP_W-1:0]          op,
    input  logic signed [lts_pkg::DATA_W-1:0] key,
    input  logic signed [lts_pkg::DATA_W-1:0] new_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lts_pkg::IDX_W-1:0]         index,
    output logic                              hit,
    output logic [lts_pkg::CNT_W-1:0]         tally,
    output logic [lts_pkg::STAT_W-1:0]        status,
    output logic                              last
);

    // Commands and status between the controller and the datapath.
    lts_pkg::cmd_t  cmd;
    lts_pkg::stat_t stat;

    // The controller sequences each operation through walk, shift and finish.
    lts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table, counters and the output register.
    lts_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op        (op),
        .key       (key),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .index     (index),
        .hit       (hit),
        .tally     (tally),
        .status    (status),
        .last      (last)
    );

`ifndef ASSERT_OFF
    // Only one operation is in flight: an accepted transaction closes the input.
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an operation was in flight");

    // The controller issues at most one command per cycle.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.mark, cmd.shift, cmd.shrink, cmd.emit_final}))
        else $error("conflicting datapath commands");

    // The closing result is written only when the output register can take it.
    a_final_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_final |-> stat.out_free)
        else $error("closing result would overwrite a pending result");

    // A reported count never exceeds the table size.
    a_tally_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tally <= lts_pkg::CNT_W'(lts_pkg::DEPTH)))
        else $error("tally out of range");
`endif

endmodule

// ----- verif/linear_table_search_edit_unit_tb.sv -----
`timescale 1ns / 100ps

// Testbench for the linear table search and edit unit.
//
// A directed opening walks the table through its corner cases: operations on
// an empty table, a table filled to capacity with one repeated value (so that
// a search reports a hit in every slot), an append into a full table, replace
// and delete that miss, and the codes that name no operation. A random part
// then runs in four phases with different amounts of sender idling and
// receiver stalling. Keys are mostly drawn from a small pool so that matches,
// multi-hit searches and deletes that succeed are common.
//
// Every accepted input transaction is run through a behavioral copy of the
// table kept in a scoreboard object, which queues the results the block must
// produce. Every accepted output transaction is compared field by field with
// the oldest queued result.
module linear_table_search_edit_unit_tb;

    // One expected result as it must leave the output channel.
    typedef struct {
        logic [lts_pkg::IDX_W-1:0]  index;
        logic                       hit;
        logic [lts_pkg::CNT_W-1:0]  tally;
        logic [lts_pkg::STAT_W-1:0] status;
        logic                       last;
    } outcome_t;

    // Shadow of the table plus the queue of results still owed by the block.
    class table_tracker;
        logic signed [lts_pkg::DATA_W-1:0] slots [lts_pkg::DEPTH];
        int                                fill;
        outcome_t                          owed [$];
        int                                errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        function int outstanding();
            return owed.size();
        endfunction

        function void owe(int idx, logic h, int cnt, logic [lts_pkg::STAT_W-1:0] st,
                          logic fin);
            outcome_t o;
            o.index  = lts_pkg::IDX_W'(idx);
            o.hit    = h;
            o.tally  = lts_pkg::CNT_W'(cnt);
            o.status = st;
            o.last   = fin;
            owed.push_back(o);
        endfunction

        // Applies one accepted operation to the shadow table and queues the
        // results it causes.
        function void note_request(logic [lts_pkg::OP_W-1:0] code,
                                   logic signed [lts_pkg::DATA_W-1:0] k,
                                   logic signed [lts_pkg::DATA_W-1:0] nv);
            int hit_count;
            int first;
            hit_count = 0;
            first     = -1;
            case (code)
                lts_pkg::OP_CLEAR:
                begin
                    fill = 0;
                    owe(0, 1'b1, 0, lts_pkg::ST_OK, 1'b1);
                end
                lts_pkg::OP_APPEND:
                begin
                    if (fill < lts_pkg::DEPTH)
                    begin
                        slots[fill] = k;
                        fill++;
                        owe(fill - 1, 1'b1, fill, lts_pkg::ST_OK, 1'b1);
                    end
                    else
                    begin
                        owe(0, 1'b0, fill, lts_pkg::ST_FULL, 1'b1);
                    end
                end
                lts_pkg::OP_SEARCH:
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        if (slots[i] == k)
                        begin
                            hit_count++;
                            owe(i, 1'b1, hit_count, lts_pkg::ST_OK, 1'b0);
                        end
                    end
                    owe(0, hit_count != 0, hit_count,
                        (hit_count != 0) ? lts_pkg::ST_OK : lts_pkg::ST_NOT_FOUND, 1'b1);
                end
                lts_pkg::OP_REPLACE:
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        if (slots[i] == k)
                        begin
                            slots[i] = nv;
                            hit_count++;
                        end
                    end
                    owe(0, hit_count != 0, hit_count,
                        (hit_count != 0) ? lts_pkg::ST_OK : lts_pkg::ST_NOT_FOUND, 1'b1);
                end
                lts_pkg::OP_DELETE:
                begin
                    for (int i = 0; i < fill && first < 0; i++)
                    begin
                        if (slots[i] == k)
                        begin
                            first = i;
                        end
                    end
                    if (first >= 0)
                    begin
                        for (int j = first; j + 1 < fill; j++)
                        begin
                            slots[j] = slots[j + 1];
                        end
                        fill--;
                        owe(first, 1'b1, fill, lts_pkg::ST_OK, 1'b1);
                    end
                    else
                    begin
                        owe(0, 1'b0, fill, lts_pkg::ST_NOT_FOUND, 1'b1);
                    end
                end
                default:
                begin
                    owe(0, 1'b0, fill, lts_pkg::ST_OK, 1'b1);
                end
            endcase
        endfunction

        // Compares one accepted result with the oldest one owed.
        task check_result(logic [lts_pkg::IDX_W-1:0] idx, logic h,
                          logic [lts_pkg::CNT_W-1:0] cnt,
                          logic [lts_pkg::STAT_W-1:0] st, logic fin);
            outcome_t o;
            if (owed.size() == 0)
            begin
                flag_mismatch($sformatf("result with none owed: index %0d tally %0d", idx, cnt));
                return;
            end
            o = owed.pop_front();
            if (idx !== o.index)
                flag_mismatch($sformatf("index %0d, wanted %0d", idx, o.index));
            if (h !== o.hit)
                flag_mismatch($sformatf("hit %0b, wanted %0b", h, o.hit));
            if (cnt !== o.tally)
                flag_mismatch($sformatf("tally %0d, wanted %0d", cnt, o.tally));
            if (st !== o.status)
                flag_mismatch($sformatf("status %0d, wanted %0d", st, o.status));
            if (fin !== o.last)
                flag_mismatch($sformatf("last %0b, wanted %0b", fin, o.last));
        endtask
    endclass

    // The slowest operation walks all sixteen entries and its control states.
    localparam int SETTLE_CYCLES = 2 * lts_pkg::DEPTH + 8;

    localparam logic signed [lts_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [lts_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [lts_pkg::OP_W-1:0]          op;
    logic signed [lts_pkg::DATA_W-1:0] key;
    logic signed [lts_pkg::DATA_W-1:0] new_value;
    logic                              out_valid;
    logic                              out_stall;
    logic [lts_pkg::IDX_W-1:0]         index;
    logic                              hit;
    logic [lts_pkg::CNT_W-1:0]         tally;
    logic [lts_pkg::STAT_W-1:0]        status;
    logic                              last;

    table_tracker tracker = new();

    // Idling knobs, changed by the main sequence at each phase boundary.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Number of cycles the receiver must still hold off unconditionally.
    int hold_left      = 0;

    logic signed [lts_pkg::DATA_W-1:0] key_pool [4];

    linear_table_search_edit_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .key       (key),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .index     (index),
        .hit       (hit),
        .tally     (tally),
        .status    (status),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Presents one transaction and returns at the edge that accepted it.
    // Idle cycles are inserted first, each with the current idle chance. When
    // there is no idling, valid simply stays high and the next payload
    // replaces the accepted one at the acceptance edge.
    task automatic send(logic [lts_pkg::OP_W-1:0] code, logic signed [lts_pkg::DATA_W-1:0] k,
                        logic signed [lts_pkg::DATA_W-1:0] nv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        key       <= k;
        new_value <= nv;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(code, k, nv);
    endtask

    // Stops offering input and waits for every owed result, then lets the
    // block finish any walk that ends without a further result.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Picks a fresh pool of keys for a phase, biased toward the value extremes.
    task automatic refresh_pool();
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(5))
                0: key_pool[i] = KEY_MIN;
                1: key_pool[i] = KEY_MAX;
                2: key_pool[i] = -1;
                default: key_pool[i] = $urandom;
            endcase
        end
    endtask

    // One random transaction. Appends dominate enough that the table often
    // reaches capacity, while deletes and the occasional clear bring it down.
    // Most keys come from the pool so that lookups actually hit.
    task automatic send_random();
        int                                pick;
        logic [lts_pkg::OP_W-1:0]          code;
        logic signed [lts_pkg::DATA_W-1:0] k;
        logic signed [lts_pkg::DATA_W-1:0] nv;
        pick = $urandom_range(99);
        k  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(3)] : $urandom;
        nv = ($urandom_range(99) < 60) ? key_pool[$urandom_range(3)] : $urandom;
        if (pick < 38)
            code = lts_pkg::OP_APPEND;
        else if (pick < 58)
            code = lts_pkg::OP_SEARCH;
        else if (pick < 72)
            code = lts_pkg::OP_REPLACE;
        else if (pick < 88)
            code = lts_pkg::OP_DELETE;
        else if (pick < 92)
            code = lts_pkg::OP_CLEAR;
        else
            code = lts_pkg::OP_W'($urandom_range(7));
        send(code, k, nv);
    endtask

    // Directed opening. The table is filled with one repeated value so that
    // a search produces a hit in every slot followed by its closing result.
    task automatic run_directed();
        send(lts_pkg::OP_CLEAR, 0, 0);
        // Every lookup on an empty table misses.
        send(lts_pkg::OP_SEARCH, KEY_MIN, 0);
        send(lts_pkg::OP_DELETE, KEY_MIN, 0);
        send(lts_pkg::OP_REPLACE, KEY_MIN, KEY_MAX);
        for (int i = 0; i < lts_pkg::DEPTH; i++)
            send(lts_pkg::OP_APPEND, KEY_MIN, 0);
        // Append into a full table is refused.
        send(lts_pkg::OP_APPEND, KEY_MAX, KEY_MIN);
        send(lts_pkg::OP_SEARCH, KEY_MIN, 0);
        send(lts_pkg::OP_REPLACE, KEY_MIN, KEY_MAX);
        send(lts_pkg::OP_DELETE, KEY_MAX, 0);
        send(lts_pkg::OP_SEARCH, KEY_MAX, -1);
        // Codes above delete leave the table alone.
        for (int c = lts_pkg::OP_DELETE + 1; c < (1 << lts_pkg::OP_W); c++)
            send(lts_pkg::OP_W'(c), -1, -1);
        send(lts_pkg::OP_CLEAR, -1, -1);
    endtask

    // Receiver. A result is taken at an edge where out_valid was high and
    // out_stall was low just before it; both are read before this edge's
    // updates land. A forced hold-off, when requested, takes precedence over
    // the random stall chance.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                tracker.check_result(index, hit, tally, status, last);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = lts_pkg::OP_CLEAR;
        key       = '0;
        new_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            refresh_pool();
            // In the first phase the receiver blocks for a long stretch while
            // the sender keeps pushing, so the block backs up into its input.
            if (phase == 0)
                hold_left = 400;
            for (int n = 0; n < 50; n++)
            begin
                send_random();
                // Mid-phase the sender stops until everything has come back.
                if (n == 25)
                    drain();
            end
            drain();
        end

        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
